[rtl/cam_pkg.sv]
// cam_pkg: shared types, constants and helpers for the conductivity autorange meter
// no dependencies; used by the interfaces and every rtl module

package cam_pkg;

  localparam int unsigned ADC_BITS_DEF = 12;
  localparam int unsigned SAMPLE_W     = 16;  // widest sample the datapath carries
  localparam int unsigned CFG_IDX_W    = 4;
  localparam int unsigned CFG_DATA_W   = 20;
  localparam int unsigned QUEUE_DEPTH  = 2;

  localparam logic [15:0] WIN_HI_WIDE = 16'd2000;
  localparam logic [15:0] WIN_LO_MID  = 16'd180;
  localparam logic [15:0] WIN_HI_3K   = 16'd1500;
  localparam logic [15:0] WIN_LO_1K   = 16'd450;

  localparam logic [36:0] COND_SCALE = 37'd100000000000;
  localparam logic [13:0] RES_SCALE  = 14'd10000;
  localparam logic [23:0] COMP_ONE   = 24'd10000000;
  localparam logic signed [16:0] REF_TEMP = 17'sd2500;
  localparam logic [39:0] MASK40     = 40'hFF_FFFF_FFFF;

  // compensation division by COMP_ONE: one 8 bit digit per step,
  // digit = (partial * COMP_RECIP) >> COMP_SHIFT, exact for partials below 2^32
  localparam logic [32:0]  COMP_RECIP  = 33'd7205759404;
  localparam int unsigned  COMP_SHIFT  = 56;
  localparam int unsigned  COMP_DIGITS = 9;

  // divider sizing: numerator left aligned, divisor up to the 42 bit denominator
  localparam int unsigned DIV_NUM_W = 70;
  localparam int unsigned DIV_DEN_W = 42;
  localparam int unsigned DIV_LEN_W = 7;

  typedef enum logic [1:0] {
    RNG_100K = 2'd0,
    RNG_10K  = 2'd1,
    RNG_3K   = 2'd2,
    RNG_1K   = 2'd3
  } rng_e;

  typedef enum logic [1:0] {
    CLS_SKIP    = 2'd0,
    CLS_FAULT   = 2'd1,
    CLS_MEASURE = 2'd2
  } cls_e;

  typedef enum logic [3:0] {
    CFG_CAL_100K  = 4'd0,
    CFG_CAL_10K   = 4'd1,
    CFG_CAL_3K    = 4'd2,
    CFG_CAL_1K    = 4'd3,
    CFG_LEAD      = 4'd4,
    CFG_CELL      = 4'd5,
    CFG_TEMP_COEF = 4'd6,
    CFG_LIQ_TEMP  = 4'd7
  } cfg_idx_e;

  typedef enum logic [3:0] {
    BK_IDLE,
    BK_MUL_A,
    BK_MUL_B,
    BK_RES_GO,
    BK_RES_WAIT,
    BK_RAW_GO,
    BK_RAW_WAIT,
    BK_MUL_C,
    BK_MUL_D,
    BK_COMP_MUL,
    BK_COMP_SUB,
    BK_OUT
  } bk_state_e;

  typedef struct packed {
    rng_e                  range_sel;  // range after this sample
    cls_e                  cls;
    logic [SAMPLE_W-1:0]   sample;
  } q_entry_t;

  typedef struct packed {
    logic [3:0][18:0]   cal_amp;
    logic [19:0]        lead_resistance;
    logic [15:0]        cell_factor;
    logic [13:0]        temp_coefficient;
    logic signed [14:0] liquid_temperature;
  } cfg_t;

  typedef struct packed {
    logic                 start;
    logic [DIV_LEN_W-1:0] len;
  } div_ctl_t;

  function automatic logic [6:0] range_kohm(input rng_e r);
    logic [6:0] k;
    case (r)
      RNG_100K: k = 7'd100;
      RNG_10K:  k = 7'd10;
      RNG_3K:   k = 7'd3;
      RNG_1K:   k = 7'd1;
      default:  k = 7'd100;
    endcase
    return k;
  endfunction

endpackage

[rtl/cam_if.sv]
// cam_if: valid/ready channels of the meter (sample in, result out, register writes)
// depends on cam_pkg

interface cam_sample_if #(
  parameter int unsigned AdcBits = cam_pkg::ADC_BITS_DEF
);
  logic               valid;
  logic               ready;
  logic [AdcBits-1:0] adc_sample;
  modport source (output valid, output adc_sample, input ready);
  modport sink   (input valid, input adc_sample, output ready);
endinterface

interface cam_result_if;
  logic        valid;
  logic        ready;
  logic [1:0]  range_select;
  logic        measure_valid;
  logic        div_fault;
  logic signed [39:0] resistance_mohm;
  logic [39:0] cond_raw;
  logic [39:0] cond_comp;
  modport source (output valid, output range_select, output measure_valid,
                  output div_fault, output resistance_mohm, output cond_raw,
                  output cond_comp, input ready);
  modport sink   (input valid, input range_select, input measure_valid,
                  input div_fault, input resistance_mohm, input cond_raw,
                  input cond_comp, output ready);
endinterface

interface cam_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cam_pkg::CFG_IDX_W-1:0]   index;
  logic [cam_pkg::CFG_DATA_W-1:0]  data;
  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

[rtl/cam_front.sv]
// cam_front: window check, range stepping and classification of each sample
// depends on cam_pkg

module cam_front #(
  parameter int unsigned ADC_BITS = cam_pkg::ADC_BITS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  input  logic [ADC_BITS-1:0] sample_i,
  output logic                ready_o,
  input  logic                full_i,
  output logic                push_o,
  output cam_pkg::q_entry_t   entry_o
);

  cam_pkg::rng_e range_q, range_d;
  logic [cam_pkg::SAMPLE_W-1:0] s;
  logic in_win;

  assign s       = cam_pkg::SAMPLE_W'(sample_i);
  assign ready_o = !full_i;
  assign push_o  = valid_i && !full_i;

  always_comb begin
    case (range_q)
      cam_pkg::RNG_100K: in_win = (s <= cam_pkg::WIN_HI_WIDE);
      cam_pkg::RNG_10K:  in_win = (s >= cam_pkg::WIN_LO_MID) && (s <= cam_pkg::WIN_HI_WIDE);
      cam_pkg::RNG_3K:   in_win = (s >= cam_pkg::WIN_LO_MID) && (s <= cam_pkg::WIN_HI_3K);
      cam_pkg::RNG_1K:   in_win = (s > cam_pkg::WIN_LO_1K);
      default:           in_win = 1'b0;
    endcase
  end

  always_comb begin
    range_d = in_win ? range_q : cam_pkg::rng_e'(range_q + 2'd1);
    entry_o.range_sel = range_d;
    entry_o.sample    = s;
    if (!in_win) begin
      entry_o.cls = cam_pkg::CLS_SKIP;
    end else if (s == '0) begin
      entry_o.cls = cam_pkg::CLS_FAULT;
    end else begin
      entry_o.cls = cam_pkg::CLS_MEASURE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      range_q <= cam_pkg::RNG_100K;
    end else if (push_o) begin
      range_q <= range_d;
    end
  end

endmodule

[rtl/cam_fifo.sv]
// cam_fifo: short request queue between the front and back parts
// depends on cam_pkg

module cam_fifo (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  cam_pkg::q_entry_t entry_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              empty_o,
  output cam_pkg::q_entry_t entry_o
);

  localparam int unsigned PtrW = $clog2(cam_pkg::QUEUE_DEPTH);

  cam_pkg::q_entry_t mem_q [cam_pkg::QUEUE_DEPTH];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q, cnt_d;

  assign full_o  = (cnt_q == (PtrW+1)'(cam_pkg::QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign entry_o = mem_q[rd_q];

  always_comb begin
    cnt_d = cnt_q;
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_q <= (wr_q == PtrW'(cam_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PtrW'(cam_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
    end
  end

endmodule

[rtl/cam_div.sv]
// cam_div: restoring divider, one quotient bit per cycle, numerator left aligned
// depends on cam_pkg

module cam_div (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cam_pkg::div_ctl_t                 ctl_i,
  input  logic [cam_pkg::DIV_NUM_W-1:0]     num_i,
  input  logic [cam_pkg::DIV_DEN_W-1:0]     den_i,
  output logic                              done_o,
  output logic [cam_pkg::DIV_NUM_W-1:0]     quo_o
);

  localparam int unsigned NW = cam_pkg::DIV_NUM_W;
  localparam int unsigned DW = cam_pkg::DIV_DEN_W;

  logic [NW-1:0] num_q, quo_q;
  logic [DW-1:0] den_q, rem_q;
  logic [DW:0]   trial;
  logic          fits;
  logic [cam_pkg::DIV_LEN_W-1:0] cnt_q;
  logic          busy_q, done_q;

  assign trial  = {rem_q, num_q[NW-1]};
  assign fits   = (trial >= {1'b0, den_q});
  assign done_o = done_q;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.start) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
      quo_q <= '0;
    end else if (busy_q) begin
      num_q <= {num_q[NW-2:0], 1'b0};
      rem_q <= fits ? DW'(trial - {1'b0, den_q}) : trial[DW-1:0];
      quo_q <= {quo_q[NW-2:0], fits};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (ctl_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= ctl_i.len;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == cam_pkg::DIV_LEN_W'(1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

[rtl/cam_back.sv]
// cam_back: sequencer that turns queued requests into result items
// depends on cam_pkg and cam_div

module cam_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cam_pkg::cfg_t        cfg_i,
  input  logic                 empty_i,
  input  cam_pkg::q_entry_t    entry_i,
  output logic                 pop_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           range_o,
  output logic                 meas_valid_o,
  output logic                 fault_o,
  output logic signed [39:0]   res_o,
  output logic [39:0]          raw_o,
  output logic [39:0]          comp_o
);

  cam_pkg::bk_state_e state_q, state_d;
  cam_pkg::q_entry_t  ent_q;
  cam_pkg::div_ctl_t  div_ctl;
  logic [cam_pkg::DIV_NUM_W-1:0] div_num, div_quo;
  logic [cam_pkg::DIV_DEN_W-1:0] div_den;
  logic div_done;

  logic [18:0] cal;
  logic [6:0]  rk;
  logic signed [14:0] tcs;
  logic signed [16:0] tdiff;
  logic [25:0] calrk_q;
  logic signed [31:0] ft_q;
  logic [52:0] snum_q;
  logic [39:0] resnum_q;
  logic [41:0] den_q;
  logic signed [32:0] f_q;
  logic [39:0] raw_q, comp_q, res_q;
  logic [49:0] prodhi_q;
  logic [71:0] prod_q;
  logic valid_q, fault_q;

  // compensation division, one 8 bit digit per pass through BK_COMP_MUL and BK_COMP_SUB
  logic [23:0] crem_q;
  logic [31:0] cpart, cpart_q;
  logic [64:0] cmul;
  logic [7:0]  cqd, cqd_q;
  logic [47:0] cquo_q, cquo_nx;
  logic [3:0]  cdig_q;

  assign cal   = cfg_i.cal_amp[ent_q.range_sel];
  assign rk    = cam_pkg::range_kohm(ent_q.range_sel);
  assign tcs   = $signed({1'b0, cfg_i.temp_coefficient});
  assign tdiff = cam_pkg::REF_TEMP - 17'(cfg_i.liquid_temperature);

  assign cpart   = {crem_q, prod_q[71:64]};
  assign cmul    = 65'(cpart) * 65'(cam_pkg::COMP_RECIP);
  assign cqd     = 8'(cmul >> cam_pkg::COMP_SHIFT);
  assign cquo_nx = {cquo_q[39:0], cqd_q};

  cam_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctl_i  (div_ctl),
    .num_i  (div_num),
    .den_i  (div_den),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      cam_pkg::BK_IDLE: begin
        if (!empty_i) begin
          state_d = (entry_i.cls == cam_pkg::CLS_MEASURE) ? cam_pkg::BK_MUL_A
                                                          : cam_pkg::BK_OUT;
        end
      end
      cam_pkg::BK_MUL_A:  state_d = cam_pkg::BK_MUL_B;
      cam_pkg::BK_MUL_B:  state_d = cam_pkg::BK_RES_GO;
      cam_pkg::BK_RES_GO: state_d = cam_pkg::BK_RES_WAIT;
      cam_pkg::BK_RES_WAIT: begin
        if (div_done) state_d = cam_pkg::BK_RAW_GO;
      end
      cam_pkg::BK_RAW_GO: begin
        state_d = (den_q == '0) ? cam_pkg::BK_MUL_C : cam_pkg::BK_RAW_WAIT;
      end
      cam_pkg::BK_RAW_WAIT: begin
        if (div_done) state_d = cam_pkg::BK_MUL_C;
      end
      cam_pkg::BK_MUL_C: begin
        state_d = (f_q > 33'sd0) ? cam_pkg::BK_MUL_D : cam_pkg::BK_OUT;
      end
      cam_pkg::BK_MUL_D:    state_d = cam_pkg::BK_COMP_MUL;
      cam_pkg::BK_COMP_MUL: state_d = cam_pkg::BK_COMP_SUB;
      cam_pkg::BK_COMP_SUB: begin
        state_d = (cdig_q == 4'd1) ? cam_pkg::BK_OUT : cam_pkg::BK_COMP_MUL;
      end
      cam_pkg::BK_OUT: begin
        if (out_ready_i) state_d = cam_pkg::BK_IDLE;
      end
      default: state_d = cam_pkg::BK_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    pop_o         = 1'b0;
    out_valid_o   = 1'b0;
    div_ctl.start = 1'b0;
    div_ctl.len   = cam_pkg::DIV_LEN_W'(40);
    div_num       = {resnum_q, 30'b0};
    div_den       = cam_pkg::DIV_DEN_W'(ent_q.sample);
    case (state_q)
      cam_pkg::BK_IDLE: pop_o = !empty_i;
      cam_pkg::BK_RES_GO: div_ctl.start = 1'b1;
      cam_pkg::BK_RAW_GO: begin
        div_ctl.start = (den_q != '0);
        div_ctl.len   = cam_pkg::DIV_LEN_W'(53);
        div_num       = {snum_q, 17'b0};
        div_den       = den_q;
      end
      cam_pkg::BK_OUT: out_valid_o = 1'b1;
      default: ;
    endcase
  end

  // datapath
  always_ff @(posedge clk_i) begin
    case (state_q)
      cam_pkg::BK_IDLE: begin
        ent_q   <= entry_i;
        res_q   <= '0;
        raw_q   <= '0;
        comp_q  <= '0;
        valid_q <= (entry_i.cls != cam_pkg::CLS_SKIP);
        fault_q <= (entry_i.cls == cam_pkg::CLS_FAULT);
      end
      cam_pkg::BK_MUL_A: begin
        calrk_q <= 26'(cal) * 26'(rk);
        ft_q    <= 32'(tcs) * 32'(tdiff);
        snum_q  <= 53'(ent_q.sample) * 53'(cam_pkg::COND_SCALE);
      end
      cam_pkg::BK_MUL_B: begin
        resnum_q <= 40'(calrk_q) * 40'(cam_pkg::RES_SCALE);
        den_q    <= 42'(calrk_q) * 42'(cfg_i.cell_factor);
        f_q      <= $signed({9'b0, cam_pkg::COMP_ONE}) + 33'(ft_q);
      end
      cam_pkg::BK_RES_WAIT: begin
        if (div_done) res_q <= div_quo[39:0] - 40'(cfg_i.lead_resistance);
      end
      cam_pkg::BK_RAW_GO: begin
        if (den_q == '0) raw_q <= cam_pkg::MASK40;
      end
      cam_pkg::BK_RAW_WAIT: begin
        if (div_done) raw_q <= (|div_quo[52:40]) ? cam_pkg::MASK40 : div_quo[39:0];
      end
      cam_pkg::BK_MUL_C: prodhi_q <= 50'(raw_q[39:20]) * 50'(f_q[29:0]);
      cam_pkg::BK_MUL_D: begin
        prod_q <= {2'b0, {prodhi_q, 20'b0} + 70'(50'(raw_q[19:0]) * 50'(f_q[29:0]))};
        crem_q <= '0;
        cquo_q <= '0;
        cdig_q <= 4'(cam_pkg::COMP_DIGITS);
      end
      cam_pkg::BK_COMP_MUL: begin
        cqd_q   <= cqd;
        cpart_q <= cpart;
        prod_q  <= {prod_q[63:0], 8'b0};
      end
      cam_pkg::BK_COMP_SUB: begin
        crem_q <= 24'(cpart_q - 32'(cqd_q) * 32'(cam_pkg::COMP_ONE));
        cquo_q <= cquo_nx;
        cdig_q <= cdig_q - 4'd1;
        if (cdig_q == 4'd1) begin
          comp_q <= (|cquo_nx[47:40]) ? cam_pkg::MASK40 : cquo_nx[39:0];
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cam_pkg::BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign range_o      = ent_q.range_sel;
  assign meas_valid_o = valid_q;
  assign fault_o      = fault_q;
  assign res_o        = res_q;
  assign raw_o        = raw_q;
  assign comp_o       = comp_q;

endmodule

[rtl/conductivity_autorange_meter.sv]
// conductivity_autorange_meter: top level with register file, front, queue and back
// depends on cam_pkg, the cam interfaces, cam_front, cam_fifo, cam_back
// a discarded or zero sample is popped and goes straight to the output state; a measured
// sample passes through up to two runs of the shared bit-serial divider (40 and 53
// quotient bits) and up to nine digit steps of the compensation division
// reset: range back to 100k, queue empty, registers to defaults; back holds one item

module conductivity_autorange_meter #(
  parameter int unsigned ADC_BITS = cam_pkg::ADC_BITS_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  cam_sample_if.sink   sample_if,
  cam_result_if.source result_if,
  cam_cfg_if.sink      cfg_if
);

  cam_pkg::cfg_t     cfg_q;
  cam_pkg::q_entry_t push_entry, pop_entry;
  logic push, pop, full, empty;
  logic signed [39:0] res;

  // register writes are always taken, unknown indexes dropped
  assign cfg_if.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.cal_amp[0]         <= 19'd25540;
      cfg_q.cal_amp[1]         <= 19'd26240;
      cfg_q.cal_amp[2]         <= 19'd26166;
      cfg_q.cal_amp[3]         <= 19'd25980;
      cfg_q.lead_resistance    <= 20'd0;
      cfg_q.cell_factor        <= 16'd1000;
      cfg_q.temp_coefficient   <= 14'd1900;
      cfg_q.liquid_temperature <= 15'sd2200;
    end else if (cfg_if.valid) begin
      case (cam_pkg::cfg_idx_e'(cfg_if.index))
        cam_pkg::CFG_CAL_100K:  cfg_q.cal_amp[0]         <= cfg_if.data[18:0];
        cam_pkg::CFG_CAL_10K:   cfg_q.cal_amp[1]         <= cfg_if.data[18:0];
        cam_pkg::CFG_CAL_3K:    cfg_q.cal_amp[2]         <= cfg_if.data[18:0];
        cam_pkg::CFG_CAL_1K:    cfg_q.cal_amp[3]         <= cfg_if.data[18:0];
        cam_pkg::CFG_LEAD:      cfg_q.lead_resistance    <= cfg_if.data[19:0];
        cam_pkg::CFG_CELL:      cfg_q.cell_factor        <= cfg_if.data[15:0];
        cam_pkg::CFG_TEMP_COEF: cfg_q.temp_coefficient   <= cfg_if.data[13:0];
        cam_pkg::CFG_LIQ_TEMP:  cfg_q.liquid_temperature <= $signed(cfg_if.data[14:0]);
        default: ;
      endcase
    end
  end

  // front: window check and range stepping, one sample per cycle while the queue has room
  cam_front #(
    .ADC_BITS (ADC_BITS)
  ) u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sample_if.valid),
    .sample_i (sample_if.adc_sample),
    .ready_o  (sample_if.ready),
    .full_i   (full),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  // queue lets the front keep classifying while the back is busy or stalled
  cam_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (push_entry),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .entry_o (pop_entry)
  );

  // back: multiply steps and shared divider, result held in its output register
  cam_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .empty_i      (empty),
    .entry_i      (pop_entry),
    .pop_o        (pop),
    .out_valid_o  (result_if.valid),
    .out_ready_i  (result_if.ready),
    .range_o      (result_if.range_select),
    .meas_valid_o (result_if.measure_valid),
    .fault_o      (result_if.div_fault),
    .res_o        (res),
    .raw_o        (result_if.cond_raw),
    .comp_o       (result_if.cond_comp)
  );

  assign result_if.resistance_mohm = res;

endmodule
